/* hdl/mbrtu_pkg.sv */
// Shared definitions for the Modbus RTU frame checker.
// Holds the result status codes, the reply constants and the CRC-16 byte step.
// No dependencies.
`default_nettype none

package mbrtu_pkg;

    typedef enum logic [2:0] {
        ST_FOREIGN   = 3'd0,
        ST_CRC_ERR   = 3'd1,
        ST_SHORT     = 3'd2,
        ST_OVERFLOW  = 3'd3,
        ST_SUPPORTED = 3'd4,
        ST_EXCEPTION = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        RB_ADDR     = 3'd0,
        RB_FUNC     = 3'd1,
        RB_CODE     = 3'd2,
        RB_CRC_LO   = 3'd3,
        RB_CRC_HI   = 3'd4
    } reply_idx_t;

    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [7:0]  BCAST_ADDR    = 8'd255;
    localparam logic [7:0]  EXC_FLAG      = 8'h80;
    localparam logic [7:0]  EXC_ILLEGAL_FN = 8'h01;
    localparam logic [7:0]  FN_WRITE_MULTI_COILS = 8'd15;
    localparam logic [7:0]  FN_WRITE_MULTI_REGS  = 8'd16;
    localparam logic [7:0]  FN_LOW_FIRST  = 8'd1;
    localparam logic [7:0]  FN_LOW_LAST   = 8'd6;

    // One byte of the reflected CRC-16, unrolled over its eight bit steps.
    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] v;
        v = c ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (v[0]) begin
                v = (v >> 1) ^ CRC_POLY;
            end else begin
                v = v >> 1;
            end
        end
        return v;
    endfunction

    function automatic logic fn_supported(input logic [7:0] f);
        return ((f >= FN_LOW_FIRST) && (f <= FN_LOW_LAST)) ||
               (f == FN_WRITE_MULTI_COILS) || (f == FN_WRITE_MULTI_REGS);
    endfunction

endpackage

`default_nettype wire

/* hdl/modbus_rtu_frame_checker_top.sv */
// Result: a byte with the end mark shows its first result in the cycle after its acceptance.
// Throughput: one byte per cycle; an exception reply holds the result register for
// five result transactions, and only a following end-marked byte waits for it.
// Reset: synchronous active-low aresetn clears the frame state, the result register
// and sets the device address to 1.
// Frame checker top level: running CRC, byte count and status/reply sequencing.
// Depends on mbrtu_pkg.
`default_nettype none

module modbus_rtu_frame_checker_top #(
    parameter int MAX_FRAME = 256
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_wr_en,
    input  wire logic [7:0] cfg_wr_data,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_rx_byte,
    input  wire logic       s_end_of_frame,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [2:0]      m_status,
    output logic [7:0]      m_function_code,
    output logic [7:0]      m_reply_byte,
    output logic            m_reply_valid,
    output logic            m_last
);

    localparam int CNT_W = $clog2(MAX_FRAME + 2);
    localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(MAX_FRAME + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME);
    localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(4);

    logic [7:0]       dev_addr_reg;
    logic [15:0]      crc_reg, crc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]       addr_reg, addr_next;
    logic [7:0]       func_reg, func_next;

    logic                 out_valid_reg;
    mbrtu_pkg::status_t   status_reg, status_next;
    logic [7:0]           out_func_reg;
    logic [7:0]           out_addr_reg;
    logic [2:0]           idx_reg;
    logic [15:0]          rcrc_reg;

    logic in_acc, out_acc, out_done, is_exc;
    logic [7:0] reply_b;

    assign is_exc   = (status_reg == mbrtu_pkg::ST_EXCEPTION);
    assign m_valid  = out_valid_reg;
    assign m_status = status_reg;
    assign m_function_code = out_func_reg;
    assign m_reply_valid = is_exc;
    assign m_reply_byte  = is_exc ? reply_b : 8'h00;
    assign m_last   = !is_exc || (idx_reg == 3'(mbrtu_pkg::RB_CRC_HI));

    assign out_acc  = out_valid_reg && m_ready;
    assign out_done = out_acc && m_last;

    // Bytes inside a frame never need the result register; only an end-marked
    // byte waits until the previous frame's results are gone.
    assign s_ready = !s_end_of_frame || !out_valid_reg || (m_ready && m_last);
    assign in_acc  = s_valid && s_ready;

    always_comb begin
        case (idx_reg)
            3'(mbrtu_pkg::RB_ADDR):   reply_b = out_addr_reg;
            3'(mbrtu_pkg::RB_FUNC):   reply_b = out_func_reg | mbrtu_pkg::EXC_FLAG;
            3'(mbrtu_pkg::RB_CODE):   reply_b = mbrtu_pkg::EXC_ILLEGAL_FN;
            3'(mbrtu_pkg::RB_CRC_LO): reply_b = rcrc_reg[7:0];
            3'(mbrtu_pkg::RB_CRC_HI): reply_b = rcrc_reg[15:8];
            default:                  reply_b = 8'h00;
        endcase
    end

    always_comb begin
        addr_next = (cnt_reg == '0) ? s_rx_byte : addr_reg;
        func_next = (cnt_reg == CNT_W'(1)) ? s_rx_byte : func_reg;
        crc_next  = mbrtu_pkg::crc_byte(crc_reg, s_rx_byte);
        cnt_next  = (cnt_reg < CNT_SAT) ? cnt_reg + CNT_W'(1) : cnt_reg;

        if (cnt_next < CNT_MIN) begin
            status_next = mbrtu_pkg::ST_SHORT;
        end else if (cnt_next > CNT_MAX) begin
            status_next = mbrtu_pkg::ST_OVERFLOW;
        end else if (addr_next != dev_addr_reg && addr_next != mbrtu_pkg::BCAST_ADDR) begin
            status_next = mbrtu_pkg::ST_FOREIGN;
        end else if (crc_next != 16'h0000) begin
            status_next = mbrtu_pkg::ST_CRC_ERR;
        end else if (mbrtu_pkg::fn_supported(func_next)) begin
            status_next = mbrtu_pkg::ST_SUPPORTED;
        end else begin
            status_next = mbrtu_pkg::ST_EXCEPTION;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_addr_reg <= 8'd1;
        end else if (cfg_wr_en) begin
            dev_addr_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg  <= mbrtu_pkg::CRC_INIT;
            cnt_reg  <= '0;
            addr_reg <= 8'h00;
            func_reg <= 8'h00;
        end else if (in_acc) begin
            if (s_end_of_frame) begin
                crc_reg  <= mbrtu_pkg::CRC_INIT;
                cnt_reg  <= '0;
                addr_reg <= 8'h00;
                func_reg <= 8'h00;
            end else begin
                crc_reg  <= crc_next;
                cnt_reg  <= cnt_next;
                addr_reg <= addr_next;
                func_reg <= func_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 3'd0;
            status_reg    <= mbrtu_pkg::ST_FOREIGN;
        end else if (in_acc && s_end_of_frame) begin
            out_valid_reg <= 1'b1;
            idx_reg       <= 3'd0;
            status_reg    <= status_next;
        end else if (out_done) begin
            out_valid_reg <= 1'b0;
        end else if (out_acc) begin
            idx_reg <= idx_reg + 3'd1;
        end
    end

    // The reply CRC is built one byte per transaction while the first three
    // reply bytes go out, so the two CRC bytes are ready when their turn comes.
    always_ff @(posedge aclk) begin
        if (in_acc && s_end_of_frame) begin
            out_func_reg <= func_next;
            out_addr_reg <= addr_next;
            rcrc_reg     <= mbrtu_pkg::CRC_INIT;
        end else if (out_acc && (idx_reg < 3'(mbrtu_pkg::RB_CRC_LO))) begin
            rcrc_reg <= mbrtu_pkg::crc_byte(rcrc_reg, reply_b);
        end
    end

`ifndef NO_ASSERTIONS
    a_eof_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_end_of_frame) |=> m_valid)
        else $error("end-marked byte produced no result");

    a_reply_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last) |=>
        (m_valid && m_status == 3'(mbrtu_pkg::ST_EXCEPTION)))
        else $error("exception reply cut short");

    a_mid_frame_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !s_end_of_frame && !m_valid) |=> !m_valid)
        else $error("result produced inside a frame");

    a_single_result_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_reply_valid) |-> (m_last && m_reply_byte == 8'h00))
        else $error("status-only result not marked last");
`endif

endmodule

`default_nettype wire
